// ----- hw/rtl/mep_pkg.sv -----
// shared constants and types for the mandelbrot escape-time pixel block
`timescale 1ns / 1ps

package mep_pkg;

    // fixed-point format of c, x and y
    localparam int MEP_FRAC_BITS = 28;
    localparam int MEP_VAL_W     = 32;
    localparam int MEP_PROD_W    = 2 * MEP_VAL_W;

    // field widths
    localparam int MEP_IDX_W     = 9;
    localparam int MEP_STEP_W    = 31;
    localparam int MEP_ITER_W    = 10;
    localparam int MEP_COLOR_W   = 24;

    // stream word widths (padded to whole bytes)
    localparam int MEP_IN_W      = 24;
    localparam int MEP_OUT_W     = 40;

    // configuration port
    localparam int MEP_ADDR_W    = 4;
    localparam int MEP_DATA_W    = 32;

    // register reset values
    localparam logic [MEP_VAL_W-1:0]  MEP_ORIGIN_RE_RST   = 32'hE000_0000;
    localparam logic [MEP_VAL_W-1:0]  MEP_ORIGIN_IM_RST   = 32'hE800_0000;
    localparam logic [MEP_STEP_W-1:0] MEP_STEP_RST        = 31'd1572864;
    localparam logic [MEP_ITER_W-1:0] MEP_ROUND_LIMIT_RST = 10'd200;

    // pixel colors
    localparam logic [MEP_COLOR_W-1:0] MEP_INSIDE_COLOR  = 24'h0000FF;
    localparam logic [MEP_COLOR_W-1:0] MEP_OUTSIDE_COLOR = 24'h000000;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_ORIGIN_RE   = 2'd0,
        REG_ORIGIN_IM   = 2'd1,
        REG_STEP        = 2'd2,
        REG_ROUND_LIMIT = 2'd3
    } reg_idx_t;

endpackage

// ----- hw/rtl/mep_mul.sv -----
// shared signed 32x32 multiplier with registered 64-bit product
`timescale 1ns / 1ps

module mep_mul
    import mep_pkg::*;
(
    input  logic                          clk,
    input  logic signed [MEP_VAL_W-1:0]   a,
    input  logic signed [MEP_VAL_W-1:0]   b,
    output logic signed [MEP_PROD_W-1:0]  p_reg
);

    // exact product, registered
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

// ----- hw/rtl/mandelbrot_escape_pixel.sv -----
// Mandelbrot escape-time evaluator for one pixel per input word
//
// Usage: write origin_re, origin_im, step and the round limit over the APB
// port (byte addresses 0, 4, 8, 12) while the block is idle. Each input word
// on the s_ channel carries a pixel column and row; c = origin + index*step is
// formed in signed fixed point and z = z^2 + c is iterated from zero.
// One result word per input word leaves on the m_ channel.
// The number of rounds run is at most the round limit; when c itself
// overflows, no round is run. All products go through one registered
// 32x32 multiplier, three products per round plus an evaluate step.
// s_tready is high only while the sequencer is idle; one pixel is in work
// at a time. The finished word sits in the output register, so a new pixel
// is taken while the receiver stalls; a second finished word waits in the
// sequencer until the output register frees.
// Reset clears the sequencer and the output valid and loads the register
// defaults (-2.0, -1.5, 3/512, 200 rounds).

module mandelbrot_escape_pixel
    import mep_pkg::*;
#(
    parameter int FRAC_BITS = MEP_FRAC_BITS
)(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [MEP_ADDR_W-1:0]   paddr,
    input  logic [MEP_DATA_W-1:0]   pwdata,
    output logic [MEP_DATA_W-1:0]   prdata,
    output logic                    pready,
    // pixel input
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [MEP_IN_W-1:0]     s_tdata,   // column[8:0], row[17:9], zero pad
    // pixel result
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [MEP_OUT_W-1:0]    m_tdata,   // iteration_count[9:0], pixel_color[33:10]
    output logic [0:0]              m_tuser    // inside_res[0]
);

    localparam int  MAG_SHIFT = 2 * FRAC_BITS + 2;
    localparam logic BOUNDED  = (MAG_SHIFT <= 63);
    localparam logic [MEP_PROD_W-1:0] MAG_LIMIT =
        BOUNDED ? (64'd1 << MAG_SHIFT) : 64'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CX,
        ST_CY,
        ST_MXX,
        ST_MYY,
        ST_MXY,
        ST_EVAL,
        ST_DONE
    } state_t;

    // configuration registers
    logic signed [MEP_VAL_W-1:0]  origin_re_reg;
    logic signed [MEP_VAL_W-1:0]  origin_im_reg;
    logic [MEP_STEP_W-1:0]        step_reg;
    logic [MEP_ITER_W-1:0]        round_limit_reg;

    // sequencer and datapath registers
    state_t                       state_reg;
    logic [MEP_IDX_W-1:0]         row_reg;
    logic                         cx_ovf_reg;
    logic signed [MEP_VAL_W-1:0]  cx_reg;
    logic signed [MEP_VAL_W-1:0]  cy_reg;
    logic signed [MEP_VAL_W-1:0]  x_reg;
    logic signed [MEP_VAL_W-1:0]  y_reg;
    logic signed [MEP_PROD_W-1:0] xx_reg;
    logic signed [MEP_PROD_W-1:0] yy_reg;
    logic [MEP_ITER_W-1:0]        round_reg;
    logic                         fresh_reg;
    logic                         res_inside_reg;
    logic [MEP_ITER_W-1:0]        res_count_reg;

    // output register
    logic                         m_tvalid_reg;
    logic                         out_inside_reg;
    logic [MEP_ITER_W-1:0]        out_count_reg;

    // multiplier connections
    logic signed [MEP_VAL_W-1:0]  mul_a;
    logic signed [MEP_VAL_W-1:0]  mul_b;
    logic signed [MEP_PROD_W-1:0] prod_reg;

    // evaluate-stage signals
    logic [41:0]                  c_sum;
    logic                         c_fits;
    logic [MEP_PROD_W-1:0]        mag;
    logic                         mag_escape;
    logic [MEP_ITER_W-1:0]        round_inc;
    logic                         limit_hit;
    logic signed [MEP_PROD_W-1:0] diff;
    logic signed [MEP_PROD_W-1:0] cx_ext;
    logic signed [MEP_PROD_W-1:0] cy_ext;
    logic signed [MEP_PROD_W-1:0] nx_wide;
    logic signed [MEP_PROD_W-1:0] ny_wide;
    logic                         step_ovf;

    logic                         cfg_wr;
    logic                         in_accept;
    logic                         out_free;

    // apb write and read
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg   <= MEP_ORIGIN_RE_RST;
            origin_im_reg   <= MEP_ORIGIN_IM_RST;
            step_reg        <= MEP_STEP_RST;
            round_limit_reg <= MEP_ROUND_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_ORIGIN_RE:   origin_re_reg   <= pwdata;
                REG_ORIGIN_IM:   origin_im_reg   <= pwdata;
                REG_STEP:        step_reg        <= pwdata[MEP_STEP_W-1:0];
                REG_ROUND_LIMIT: round_limit_reg <= pwdata[MEP_ITER_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_ORIGIN_RE:   prdata = origin_re_reg;
            REG_ORIGIN_IM:   prdata = origin_im_reg;
            REG_STEP:        prdata = {1'b0, step_reg};
            REG_ROUND_LIMIT: prdata = {22'd0, round_limit_reg};
            default:         prdata = '0;
        endcase
    end

    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign out_free  = ~m_tvalid_reg | m_tready;

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = {23'd0, s_tdata[MEP_IDX_W-1:0]};
                mul_b = {1'b0, step_reg};
            end
            ST_CX:
            begin
                mul_a = {23'd0, row_reg};
                mul_b = {1'b0, step_reg};
            end
            ST_MXX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            ST_MYY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    mep_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod_reg)
    );

    // c = origin + index*step, origin chosen by state
    always_comb
    begin
        if (state_reg == ST_CX)
            c_sum = {{10{origin_re_reg[31]}}, origin_re_reg} + {1'b0, prod_reg[40:0]};
        else
            c_sum = {{10{origin_im_reg[31]}}, origin_im_reg} + {1'b0, prod_reg[40:0]};
    end
    assign c_fits = (&c_sum[41:31]) | ~(|c_sum[41:31]);

    // escape test on the previous round's z
    assign mag        = xx_reg + yy_reg;
    assign mag_escape = fresh_reg & BOUNDED & (mag > MAG_LIMIT);
    assign round_inc  = round_reg + MEP_ITER_W'(fresh_reg);
    assign limit_hit  = (round_inc >= round_limit_reg);

    // next z, product of x and y straight from the multiplier
    assign diff     = xx_reg - yy_reg;
    assign cx_ext   = {{32{cx_reg[31]}}, cx_reg};
    assign cy_ext   = {{32{cy_reg[31]}}, cy_reg};
    assign nx_wide  = cx_ext + (diff >>> FRAC_BITS);
    assign ny_wide  = cy_ext + (prod_reg >>> (FRAC_BITS - 1));
    assign step_ovf = ~((&nx_wide[63:31]) | ~(|nx_wide[63:31]))
                    | ~((&ny_wide[63:31]) | ~(|ny_wide[63:31]));

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            fresh_reg    <= 1'b0;
        end
        else
        begin
            // load a finished word, or free the register once taken
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg   <= 1'b1;
                out_inside_reg <= res_inside_reg;
                out_count_reg  <= res_count_reg;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        row_reg   <= s_tdata[2*MEP_IDX_W-1:MEP_IDX_W];
                        state_reg <= ST_CX;
                    end
                end
                ST_CX:
                begin
                    cx_reg     <= c_sum[31:0];
                    cx_ovf_reg <= ~c_fits;
                    state_reg  <= ST_CY;
                end
                ST_CY:
                begin
                    cy_reg <= c_sum[31:0];
                    if (cx_ovf_reg || !c_fits)
                    begin
                        res_inside_reg <= 1'b0;
                        res_count_reg  <= '0;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        x_reg     <= '0;
                        y_reg     <= '0;
                        round_reg <= '0;
                        fresh_reg <= 1'b0;
                        state_reg <= ST_MXX;
                    end
                end
                ST_MXX:
                begin
                    state_reg <= ST_MYY;
                end
                ST_MYY:
                begin
                    xx_reg    <= prod_reg;
                    state_reg <= ST_MXY;
                end
                ST_MXY:
                begin
                    yy_reg    <= prod_reg;
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (mag_escape)
                    begin
                        res_inside_reg <= 1'b0;
                        res_count_reg  <= round_reg;
                        state_reg      <= ST_DONE;
                    end
                    else if (limit_hit)
                    begin
                        res_inside_reg <= 1'b1;
                        res_count_reg  <= round_inc;
                        state_reg      <= ST_DONE;
                    end
                    else if (step_ovf)
                    begin
                        res_inside_reg <= 1'b0;
                        res_count_reg  <= round_inc;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        x_reg     <= nx_wide[31:0];
                        y_reg     <= ny_wide[31:0];
                        round_reg <= round_inc;
                        fresh_reg <= 1'b1;
                        state_reg <= ST_MXX;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result word
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_inside_reg;
    assign m_tdata  = {6'd0,
                       (out_inside_reg ? MEP_INSIDE_COLOR : MEP_OUTSIDE_COLOR),
                       out_count_reg};

endmodule
